FILE: src/tga_dec_pkg.sv
// tga_dec_pkg: shared types and constants for the TGA pixel stream decoder.
// No dependencies; imported by the config channel interface, tga_dec_seg and the top level.
`default_nettype none
package tga_dec_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_UP    = 3'd4;

  localparam logic [15:0] MIN_WIDTH     = 16'd4;
  localparam int unsigned PKT_TYPE_BIT  = 7;

  typedef enum logic [1:0] {
    ST_IDLE,  // taking bytes
    ST_SEG,   // segment unit computes next segment
    ST_OUT    // segment held on the result channel
  } tga_dec_state_t;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic        bottom_up;
  } tga_dec_geom_t;

  typedef struct packed {
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] rows_done;
    logic [7:0]  count;
  } tga_dec_seg_req_t;

  typedef struct packed {
    logic [7:0]  run_length;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] rows_done;
    logic [7:0]  count;
    logic        last;
    logic        image_done;
  } tga_dec_seg_res_t;

endpackage
`default_nettype wire

FILE: src/tga_dec_ifs.sv
// Valid/ready channel interfaces: pixel bytes in, segments out, config writes.
// Depends on tga_dec_pkg.
`default_nettype none

interface tga_dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  modport source (output valid, data_byte, first_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface tga_dec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [7:0]  run_length;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        alpha_present;
  logic        last_segment;
  logic        image_done;
  modport source (output valid, pixel_x, pixel_y, run_length, red, green, blue, alpha,
                  alpha_present, last_segment, image_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, run_length, red, green, blue, alpha,
                  alpha_present, last_segment, image_done, output ready);
endinterface

interface tga_dec_cfg_if import tga_dec_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/tga_dec_seg.sv
// tga_dec_seg: segment unit, cuts one run at the row end and steps the position.
// Depends on tga_dec_pkg. Used once per segment by the top-level sequencer.
`default_nettype none
module tga_dec_seg import tga_dec_pkg::*; (
  input  tga_dec_geom_t    geom,
  input  tga_dec_seg_req_t req,
  output tga_dec_seg_res_t res
);

  logic [15:0] w;
  logic [15:0] avail;
  logic [7:0]  seg;
  logic [16:0] col_sum;
  logic        wrap;

  always_comb begin
    w     = (geom.width < MIN_WIDTH) ? MIN_WIDTH : geom.width;
    // column past a lowered width still takes one pixel, then wraps
    avail = (req.column < w) ? (w - req.column) : 16'd1;
    seg   = ({8'd0, req.count} < avail) ? req.count : avail[7:0];
    col_sum = {1'b0, req.column} + {9'd0, seg};
    wrap    = (col_sum >= {1'b0, w});

    res.run_length = seg;
    res.count      = req.count - seg;
    res.column     = wrap ? 16'd0 : col_sum[15:0];
    res.row        = req.row;
    res.rows_done  = req.rows_done;
    if (wrap) begin
      res.row       = geom.bottom_up ? (req.row - 16'd1) : (req.row + 16'd1);
      res.rows_done = req.rows_done + 16'd1;
    end
    res.image_done = wrap && (res.rows_done >= geom.height);
    res.last       = (res.count == 8'd0) || (res.rows_done >= geom.height);
  end

endmodule
`default_nettype wire

FILE: src/tga_pixel_stream_decoder_unit.sv
// Top level of the TGA pixel stream decoder: byte parser, sequencer, result register.
// Depends on tga_dec_pkg, tga_dec_ifs (channel interfaces) and tga_dec_seg.
//
//  channel  | dir | transfer moves                         | ready
//  ---------+-----+----------------------------------------+---------------------------
//  in_bus   | in  | one pixel-data byte + first_byte flag  | high only in ST_IDLE
//  out_bus  | out | one pixel run segment (x, y, len, RGBA)| from sink
//  cfg_bus  | in  | register index + 16-bit write data     | always high
//
// Sequence: a header byte or a non-final pixel byte is taken in ST_IDLE alone. The byte
// that completes a pixel then passes once per segment through ST_SEG (segment unit, then
// the result register) and ST_OUT, up to 33 segments for a 128-pixel run over 4-pixel rows.
// The single segment unit is reused once per segment.
// Reset (rst_n low, synchronous) loads the register defaults and the packet state.
// A stalled result holds the block in ST_OUT; no byte is taken meanwhile.
`default_nettype none
module tga_pixel_stream_decoder_unit import tga_dec_pkg::*; (
  input  wire            clk,
  input  wire            rst_n,
  tga_dec_in_if.sink     in_bus,
  tga_dec_out_if.source  out_bus,
  tga_dec_cfg_if.sink    cfg_bus
);

  tga_dec_state_t state_r, state_nxt;

  // configuration
  logic        rle_mode_r, four_byte_r, bottom_up_r;
  logic [15:0] width_r, height_r;

  // packet and position state
  logic        expect_hdr_r, expect_hdr_nxt;
  logic        repeat_r, repeat_nxt;
  logic [7:0]  pix_left_r, pix_left_nxt;
  logic [1:0]  byte_idx_r, byte_idx_nxt;
  logic [23:0] held_r, held_nxt;
  logic [15:0] column_r, column_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] rows_done_r, rows_done_nxt;
  logic [7:0]  count_r, count_nxt;

  // pixel value of the run being emitted
  logic [7:0]  red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt, alpha_r, alpha_nxt;
  logic        ap_r, ap_nxt;

  // result register
  logic [15:0] x_r, y_r;
  logic [7:0]  len_r;
  logic        last_r, done_r;

  logic in_xfer, out_xfer, cfg_xfer, pixel_done;

  // view after an optional restart on first_byte
  logic        eff_expect, eff_repeat;
  logic [7:0]  eff_left;
  logic [1:0]  eff_idx;
  logic [23:0] eff_held;
  logic [15:0] eff_column, eff_row, eff_rows_done;
  logic [1:0]  last_idx;
  logic [7:0]  d;

  tga_dec_geom_t    geom;
  tga_dec_seg_req_t seg_req;
  tga_dec_seg_res_t seg_res;

  assign in_xfer  = in_bus.valid && in_bus.ready;
  assign out_xfer = out_bus.valid && out_bus.ready;
  assign cfg_xfer = cfg_bus.valid && cfg_bus.ready;

  assign geom    = '{width: width_r, height: height_r, bottom_up: bottom_up_r};
  assign seg_req = '{column: column_r, row: row_r, rows_done: rows_done_r, count: count_r};

  tga_dec_seg u_seg (
    .geom (geom),
    .req  (seg_req),
    .res  (seg_res)
  );

  // handshake outputs
  always_comb begin
    in_bus.ready  = (state_r == ST_IDLE);
    out_bus.valid = (state_r == ST_OUT);
    cfg_bus.ready = 1'b1;
  end

  assign out_bus.pixel_x       = x_r;
  assign out_bus.pixel_y       = y_r;
  assign out_bus.run_length    = len_r;
  assign out_bus.red           = red_r;
  assign out_bus.green         = green_r;
  assign out_bus.blue          = blue_r;
  assign out_bus.alpha         = alpha_r;
  assign out_bus.alpha_present = ap_r;
  assign out_bus.last_segment  = last_r;
  assign out_bus.image_done    = done_r;

  // byte parser
  always_comb begin
    d        = in_bus.data_byte;
    last_idx = four_byte_r ? 2'd3 : 2'd2;

    if (in_bus.first_byte) begin
      eff_expect    = 1'b1;
      eff_repeat    = 1'b0;
      eff_left      = 8'd0;
      eff_idx       = 2'd0;
      eff_held      = 24'd0;
      eff_column    = 16'd0;
      eff_row       = bottom_up_r ? (height_r - 16'd1) : 16'd0;
      eff_rows_done = 16'd0;
    end else begin
      eff_expect    = expect_hdr_r;
      eff_repeat    = repeat_r;
      eff_left      = pix_left_r;
      eff_idx       = byte_idx_r;
      eff_held      = held_r;
      eff_column    = column_r;
      eff_row       = row_r;
      eff_rows_done = rows_done_r;
    end

    expect_hdr_nxt = expect_hdr_r;
    repeat_nxt     = repeat_r;
    pix_left_nxt   = pix_left_r;
    byte_idx_nxt   = byte_idx_r;
    held_nxt       = held_r;
    column_nxt     = column_r;
    row_nxt        = row_r;
    rows_done_nxt  = rows_done_r;
    count_nxt      = count_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    blue_nxt       = blue_r;
    alpha_nxt      = alpha_r;
    ap_nxt         = ap_r;
    pixel_done     = 1'b0;

    if (state_r == ST_IDLE && in_xfer) begin
      expect_hdr_nxt = eff_expect;
      repeat_nxt     = eff_repeat;
      pix_left_nxt   = eff_left;
      byte_idx_nxt   = eff_idx;
      held_nxt       = eff_held;
      column_nxt     = eff_column;
      row_nxt        = eff_row;
      rows_done_nxt  = eff_rows_done;

      priority if (eff_rows_done >= height_r) begin
        // image complete: byte dropped
      end else if (rle_mode_r && eff_expect) begin
        repeat_nxt     = d[PKT_TYPE_BIT];
        pix_left_nxt   = {1'b0, d[6:0]} + 8'd1;
        expect_hdr_nxt = 1'b0;
        byte_idx_nxt   = 2'd0;
      end else if (eff_idx < last_idx) begin
        unique case (eff_idx)
          2'd0:    held_nxt[7:0]   = d;
          2'd1:    held_nxt[15:8]  = d;
          default: held_nxt[23:16] = d;
        endcase
        byte_idx_nxt = eff_idx + 2'd1;
      end else begin
        pixel_done   = 1'b1;
        blue_nxt     = eff_held[7:0];
        green_nxt    = eff_held[15:8];
        red_nxt      = four_byte_r ? eff_held[23:16] : d;
        ap_nxt       = four_byte_r && rle_mode_r;
        alpha_nxt    = (four_byte_r && rle_mode_r) ? d : 8'd0;
        byte_idx_nxt = 2'd0;
        count_nxt    = 8'd1;
        if (rle_mode_r) begin
          if (eff_repeat) begin
            // empty count after a mode change acts as one pixel
            count_nxt      = (eff_left != 8'd0) ? eff_left : 8'd1;
            pix_left_nxt   = 8'd0;
            expect_hdr_nxt = 1'b1;
          end else if (eff_left <= 8'd1) begin
            pix_left_nxt   = 8'd0;
            expect_hdr_nxt = 1'b1;
          end else begin
            pix_left_nxt = eff_left - 8'd1;
          end
        end
      end
    end else if (state_r == ST_SEG) begin
      column_nxt    = seg_res.column;
      row_nxt       = seg_res.row;
      rows_done_nxt = seg_res.rows_done;
      count_nxt     = seg_res.count;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pixel_done) state_nxt = ST_SEG;
      ST_SEG:  state_nxt = ST_OUT;
      ST_OUT:  if (out_xfer) state_nxt = last_r ? ST_IDLE : ST_SEG;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rle_mode_r   <= 1'b0;
      four_byte_r  <= 1'b0;
      width_r      <= MIN_WIDTH;
      height_r     <= 16'd1;
      bottom_up_r  <= 1'b1;
      expect_hdr_r <= 1'b1;
      repeat_r     <= 1'b0;
      pix_left_r   <= 8'd0;
      byte_idx_r   <= 2'd0;
      held_r       <= 24'd0;
      column_r     <= 16'd0;
      row_r        <= 16'd0;
      rows_done_r  <= 16'd0;
      count_r      <= 8'd0;
    end else begin
      state_r      <= state_nxt;
      expect_hdr_r <= expect_hdr_nxt;
      repeat_r     <= repeat_nxt;
      pix_left_r   <= pix_left_nxt;
      byte_idx_r   <= byte_idx_nxt;
      held_r       <= held_nxt;
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      rows_done_r  <= rows_done_nxt;
      count_r      <= count_nxt;
      if (cfg_xfer) begin
        unique case (cfg_bus.index)
          CFG_RLE_MODE:     rle_mode_r  <= cfg_bus.data[0];
          CFG_FOUR_BYTE:    four_byte_r <= cfg_bus.data[0];
          CFG_IMAGE_WIDTH:  width_r     <= cfg_bus.data;
          CFG_IMAGE_HEIGHT: height_r    <= cfg_bus.data;
          CFG_BOTTOM_UP:    bottom_up_r <= cfg_bus.data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    alpha_r <= alpha_nxt;
    ap_r    <= ap_nxt;
    if (state_r == ST_SEG) begin
      x_r    <= column_r;
      y_r    <= row_r;
      len_r  <= seg_res.run_length;
      last_r <= seg_res.last;
      done_r <= seg_res.image_done;
    end
  end

  // no byte taken while a segment is on offer
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_bus.ready && out_bus.valid))
    else $error("input ready while a segment is pending");

  // the final segment of a byte returns the block to taking bytes
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_bus.last_segment) |=> in_bus.ready)
    else $error("not ready after final segment");

  // completing the image ends the byte's output
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.image_done) |-> out_bus.last_segment)
    else $error("image_done without last_segment");

  // a segment always covers at least one pixel
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.run_length != 8'd0))
    else $error("empty segment");

endmodule
`default_nettype wire
